// File: rtl/core/bssc_pkg.sv
// shared constants, types and modular add for the bounded step sequence counter
package bssc_pkg;

   // payload widths
   localparam int unsigned ELEM_W = 8;
   localparam int unsigned MAXV_W = 8;
   localparam int unsigned WAYS_W = 30;

   // default row size and register reset value
   localparam int unsigned MAX_VALUE_LIMIT_DEF = 128;
   localparam logic [MAXV_W-1:0] MAX_VALUE_RESET = 8'd100;

   // counts are kept modulo this prime
   localparam logic [WAYS_W-1:0] COUNT_MOD = 30'd1000000007;

   // command from the control fsm to the row engine
   typedef struct packed {
      logic              start;
      logic              first;
      logic [ELEM_W-1:0] elem;
   } row_cmd_type;

   // status from the row engine back to the control fsm
   typedef struct packed {
      logic              done;
      logic [WAYS_W-1:0] sum;
   } row_stat_type;

   // sum of two reduced counts, reduced again
   function automatic logic [WAYS_W-1:0] mod_add(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
      logic [WAYS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, COUNT_MOD}) begin
         s = s - {1'b0, COUNT_MOD};
      end
      return s[WAYS_W-1:0];
   endfunction

endpackage

// File: rtl/core/bssc_if.sv
// request, response and register write channel interfaces

// request channel: one sequence position
interface bssc_req_if;
   import bssc_pkg::*;
   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] element_value;
   logic              is_last;
   modport source (output valid, output element_value, output is_last, input ready);
   modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

// response channel: sequence count
interface bssc_rsp_if;
   import bssc_pkg::*;
   logic              valid;
   logic              ready;
   logic [WAYS_W-1:0] ways;
   modport source (output valid, output ways, input ready);
   modport sink   (input valid, input ways, output ready);
endinterface

// register write channel: max_value
interface bssc_csr_if;
   import bssc_pkg::*;
   logic              valid;
   logic              ready;
   logic [MAXV_W-1:0] max_value;
   modport source (output valid, output max_value, input ready);
   modport sink   (input valid, input max_value, output ready);
endinterface

// File: rtl/core/bssc_row_engine.sv
// count row memory with one read-modify-write pass per request
module bssc_row_engine #(
   parameter int unsigned MAX_VALUE_LIMIT = bssc_pkg::MAX_VALUE_LIMIT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bssc_pkg::row_cmd_type        cmd,
   input  logic [bssc_pkg::MAXV_W-1:0]  max_value,
   output bssc_pkg::row_stat_type       stat
);
   import bssc_pkg::*;

   localparam int unsigned AW = $clog2(MAX_VALUE_LIMIT);
   localparam int unsigned CW = ((AW > MAXV_W) ? AW : MAXV_W) + 1;
   localparam logic [CW-1:0] LIMIT_C = CW'(MAX_VALUE_LIMIT);

   // count row, entry k holds the count for value k+1
   logic [WAYS_W-1:0] mem [MAX_VALUE_LIMIT];

   // pass control
   logic              run_ff, run_in;
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              first_ff;
   logic [ELEM_W-1:0] elem_ff;
   logic [AW-1:0]     rd_addr;

   // read arrival stage
   logic              arr_vld_ff;
   logic [CW-1:0]     arr_idx_ff;
   logic [WAYS_W-1:0] rdata_ff;

   // sliding window over the old row
   logic [WAYS_W-1:0] a_ff, a_in;
   logic [WAYS_W-1:0] pair_ff, pair_in;

   // write stage
   logic              wr_vld_ff, wr_vld_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [WAYS_W-1:0] wr_data_ff, wr_data_in;
   logic              wr_last_ff, wr_last_in;

   logic [WAYS_W-1:0] sum_ff;
   logic              done_ff;

   logic [CW-1:0]     m_eff;
   logic [CW-1:0]     k_idx;
   logic [WAYS_W-1:0] old_j;
   logic [WAYS_W-1:0] sum3;
   logic              allowed;

   // effective value limit, clamped to the row size
   always_comb begin
      m_eff = (CW'(max_value) > LIMIT_C) ? LIMIT_C : CW'(max_value);
   end

   // read counter walks 0..LIMIT, the last step is the zero edge entry
   always_comb begin
      run_in    = run_ff && (rd_cnt_ff != LIMIT_C);
      rd_cnt_in = rd_cnt_ff + 1'b1;
      if (cmd.start) begin
         run_in    = 1'b1;
         rd_cnt_in = '0;
      end
      rd_addr = (rd_cnt_ff == LIMIT_C) ? '0 : rd_cnt_ff[AW-1:0];
   end

   // new entry k = old k-1 + old k + old k+1, masked by value limit and fixed value
   always_comb begin
      old_j      = (arr_idx_ff < m_eff) ? rdata_ff : '0;
      sum3       = mod_add(pair_ff, old_j);
      pair_in    = mod_add(a_ff, old_j);
      a_in       = old_j;
      k_idx      = arr_idx_ff - 1'b1;
      allowed    = (k_idx < m_eff) &&
                   ((elem_ff == '0) || (CW'(elem_ff) == arr_idx_ff));
      wr_data_in = allowed ? (first_ff ? WAYS_W'(1) : sum3) : '0;
      wr_vld_in  = arr_vld_ff && (arr_idx_ff != '0);
      wr_addr_in = k_idx[AW-1:0];
      wr_last_in = (arr_idx_ff == LIMIT_C);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         rd_cnt_ff  <= '0;
         arr_vld_ff <= 1'b0;
         wr_vld_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         run_ff     <= run_in;
         rd_cnt_ff  <= rd_cnt_in;
         arr_vld_ff <= run_ff;
         wr_vld_ff  <= wr_vld_in;
         done_ff    <= wr_vld_ff && wr_last_ff;
      end
   end

   // request fields latched for the pass
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         first_ff <= cmd.first;
         elem_ff  <= cmd.elem;
      end
   end

   // memory read port, registered read data
   always_ff @(posedge clock) begin
      arr_idx_ff <= rd_cnt_ff;
      if (run_ff) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // window registers, cleared at pass start for the zero low edge
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff    <= '0;
         pair_ff <= '0;
      end else if (arr_vld_ff) begin
         a_ff    <= a_in;
         pair_ff <= pair_in;
      end
   end

   // write stage registers
   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
      wr_last_ff <= wr_last_in;
   end

   // memory write port and running sum of the new row
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sum_ff <= '0;
      end else if (wr_vld_ff) begin
         sum_ff <= mod_add(sum_ff, wr_data_ff);
      end
      if (wr_vld_ff) begin
         mem[wr_addr_ff] <= wr_data_ff;
      end
   end

   assign stat.done = done_ff;
   assign stat.sum  = sum_ff;

endmodule

// File: rtl/core/bounded_step_sequence_counter.sv
// top level: request control, register and response output of the sequence counter
//
//   channel   dir  payload                  meaning
//   req_chan  in   element_value, is_last   one sequence position
//   rsp_chan  out  ways                     count of sequences, on a last position
//   csr_chan  in   max_value                largest allowed value
//
// each request holds the request channel until the row engine has walked the whole
// count row once through its single read and single write memory port; a last request
// also loads the response register before the next request is accepted.
// reset needs no clearing pass: the first request of a sequence rewrites every entry.
// a finished count waits in the response register; a last request that completes
// while that register is still full holds until it drains.
module bounded_step_sequence_counter #(
   parameter int unsigned MAX_VALUE_LIMIT = bssc_pkg::MAX_VALUE_LIMIT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bssc_req_if.sink   req_chan,
   bssc_rsp_if.source rsp_chan,
   bssc_csr_if.sink   csr_chan
);
   import bssc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic              first_ff, first_in;
   logic              last_ff;
   logic [MAXV_W-1:0] max_value_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WAYS_W-1:0] ways_ff;
   logic              req_take;
   logic              emit;
   row_cmd_type       cmd;
   row_stat_type      stat;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_take       = req_chan.valid && req_chan.ready;

   // start a row pass on each request
   assign cmd.start = req_take;
   assign cmd.first = first_ff;
   assign cmd.elem  = req_chan.element_value;

   // response register frees up when taken
   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // control fsm
   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_BUSY;
               first_in = 1'b0;
            end
         end
         ST_BUSY: begin
            if (stat.done) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in     = ST_IDLE;
               first_in     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         max_value_ff <= MAX_VALUE_RESET;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            max_value_ff <= csr_chan.max_value;
         end
      end
   end

   // request last mark and response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         last_ff <= req_chan.is_last;
      end
      if (emit) begin
         ways_ff <= stat.sum;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ways  = ways_ff;

   bssc_row_engine #(
      .MAX_VALUE_LIMIT (MAX_VALUE_LIMIT)
   ) u_row_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .max_value (max_value_ff),
      .stat      (stat)
   );

endmodule
